// ===== rtl/rgb8_to_hsv_converter_unit_defines.svh =====
// ------------------------------------------------------------------------
// RGB8 to HSV converter: assertion macros
// Shared property wrappers for the checker.
// ------------------------------------------------------------------------
`ifndef RGB8_TO_HSV_CONVERTER_UNIT_DEFINES_SVH
`define RGB8_TO_HSV_CONVERTER_UNIT_DEFINES_SVH

// clocked property, ignored while reset is asserted
`define RGBHSV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked property that also holds across reset
`define RGBHSV_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/rgbhsv_pkg.sv =====
// ------------------------------------------------------------------------
// RGB8 to HSV converter package
// Widths, hue constants and pipeline payload types.
// ------------------------------------------------------------------------
package rgbhsv_pkg;

    localparam int IN_W       = 24;
    localparam int OUT_W      = 40;
    localparam int DIV_STAGES = 8;

    localparam logic [22:0] HUE_SIXTH_X2 = 23'd7680;
    localparam logic [15:0] HUE_GREEN    = 16'd7680;
    localparam logic [15:0] HUE_BLUE     = 16'd15360;
    localparam logic [15:0] HUE_FULL     = 16'd23040;

    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } t_hue_sel;

    // one long-division lane: partial remainder, numerator/quotient shifter, divisor
    typedef struct packed {
        logic [7:0]  rem;
        logic [15:0] nq;
        logic [7:0]  dvs;
    } t_div_lane;

    typedef struct packed {
        t_hue_sel sel;
        logic     neg;
    } t_side;

    typedef struct packed {
        t_div_lane sat;
        t_div_lane hue;
        t_side     side;
    } t_div_item;

endpackage

// ===== rtl/rgbhsv_front.sv =====
// ------------------------------------------------------------------------
// RGB8 to HSV front end
// Max/min search, channel difference, then division operand setup.
// ------------------------------------------------------------------------
module rgbhsv_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [rgbhsv_pkg::IN_W-1:0]  i_data,
    input  logic [1:0]                   i_ld,
    output logic [1:0]                   o_valid,
    output rgbhsv_pkg::t_div_item        o_item
);
    import rgbhsv_pkg::*;

    logic [7:0]  red, green, blue;
    logic [7:0]  n_mx, n_mn, n_c, n_absd;
    logic        n_neg;
    t_hue_sel    n_sel;
    logic signed [8:0] diff;

    logic [7:0]  r_a_mx, r_a_c, r_a_absd;
    logic        r_a_neg;
    t_hue_sel    r_a_sel;
    logic        r_a_valid;

    logic [22:0] n_sat_num, n_hue_num;
    t_div_item   n_item;
    t_div_item   r_item;
    logic        r_b_valid;

    assign red   = i_data[7:0];
    assign green = i_data[15:8];
    assign blue  = i_data[23:16];

    always_comb begin
        n_mx = red;
        n_mn = red;
        if (green > n_mx) n_mx = green;
        if (blue > n_mx) n_mx = blue;
        if (green < n_mn) n_mn = green;
        if (blue < n_mn) n_mn = blue;
        n_c = n_mx - n_mn;
        // red wins ties, then green
        if (n_mx == red) begin
            n_sel = SEL_RED;
            diff  = $signed({1'b0, green}) - $signed({1'b0, blue});
        end else if (n_mx == green) begin
            n_sel = SEL_GREEN;
            diff  = $signed({1'b0, blue}) - $signed({1'b0, red});
        end else begin
            n_sel = SEL_BLUE;
            diff  = $signed({1'b0, red}) - $signed({1'b0, green});
        end
        n_neg  = diff[8];
        n_absd = diff[8] ? 8'(-diff) : diff[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_ld[0]) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r_a_mx   <= n_mx;
            r_a_c    <= n_c;
            r_a_absd <= n_absd;
            r_a_neg  <= n_neg;
            r_a_sel  <= n_sel;
        end
    end

    // sat numerator c*32768 + mx/2, hue numerator 7680*|diff|; both stay below 2^16 * divisor
    always_comb begin
        n_sat_num = {r_a_c, 15'd0} + {16'd0, r_a_mx[7:1]};
        n_hue_num = 23'(r_a_absd) * HUE_SIXTH_X2;
        n_item.sat.rem   = {1'b0, n_sat_num[22:16]};
        n_item.sat.nq    = n_sat_num[15:0];
        n_item.sat.dvs   = r_a_mx;
        n_item.hue.rem   = {1'b0, n_hue_num[22:16]};
        n_item.hue.nq    = n_hue_num[15:0];
        n_item.hue.dvs   = r_a_c;
        n_item.side.sel  = r_a_sel;
        n_item.side.neg  = r_a_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_ld[1]) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[1]) begin
            r_item <= n_item;
        end
    end

    assign o_valid = {r_b_valid, r_a_valid};
    assign o_item  = r_item;

endmodule

// ===== rtl/rgbhsv_div_stage.sv =====
// ------------------------------------------------------------------------
// RGB8 to HSV divider stage
// Two restoring long-division steps on both lanes, then a register.
// ------------------------------------------------------------------------
module rgbhsv_div_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_ld,
    input  rgbhsv_pkg::t_div_item i_item,
    output logic                  o_valid,
    output rgbhsv_pkg::t_div_item o_item
);
    import rgbhsv_pkg::*;

    function automatic t_div_lane div_step(input t_div_lane lane);
        t_div_lane  nxt;
        logic [8:0] trial;
        nxt   = lane;
        trial = {lane.rem, lane.nq[15]};
        if (trial >= {1'b0, lane.dvs}) begin
            nxt.rem = 8'(trial - {1'b0, lane.dvs});
            nxt.nq  = {lane.nq[14:0], 1'b1};
        end else begin
            nxt.rem = trial[7:0];
            nxt.nq  = {lane.nq[14:0], 1'b0};
        end
        return nxt;
    endfunction

    t_div_item n_item;
    t_div_item r_item;
    logic      r_valid;

    always_comb begin
        n_item      = i_item;
        n_item.sat  = div_step(div_step(i_item.sat));
        n_item.hue  = div_step(div_step(i_item.hue));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ld) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/rgbhsv_back.sv =====
// ------------------------------------------------------------------------
// RGB8 to HSV back end
// Hue rounding, sector offset and wrap; black/grey overrides; output register.
// ------------------------------------------------------------------------
module rgbhsv_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_ld,
    input  rgbhsv_pkg::t_div_item        i_item,
    output logic                         o_valid,
    output logic [rgbhsv_pkg::OUT_W-1:0] o_data
);
    import rgbhsv_pkg::*;

    logic [13:0]        q_up;
    logic signed [14:0] t2;
    logic signed [15:0] t2_p1;
    logic signed [15:0] half;
    logic signed [15:0] base;
    logic signed [15:0] hue_s;
    logic [14:0]        n_hue;
    logic [15:0]        n_sat;
    logic [7:0]         n_val;

    logic [OUT_W-1:0]   r_data;
    logic               r_valid;

    // t2 = floor(2*hue_frac); a negative difference needs the ceiling of the magnitude
    always_comb begin
        q_up  = {1'b0, i_item.hue.nq[12:0]}
              + {13'd0, (i_item.side.neg && (i_item.hue.rem != 8'd0))};
        t2    = i_item.side.neg ? -$signed({1'b0, q_up}) : $signed({1'b0, q_up});
        t2_p1 = 16'(t2) + 16'sd1;
        half  = t2_p1 >>> 1;
        case (i_item.side.sel)
            SEL_RED:   base = 16'sd0;
            SEL_GREEN: base = $signed(HUE_GREEN);
            SEL_BLUE:  base = $signed(HUE_BLUE);
            default:   base = 16'sd0;
        endcase
        hue_s = half + base;
        if (hue_s < 16'sd0) begin
            hue_s = hue_s + $signed(HUE_FULL);
        end
        n_hue = (i_item.hue.dvs == 8'd0) ? 15'd0 : hue_s[14:0];
        n_sat = (i_item.sat.dvs == 8'd0) ? 16'd0 : i_item.sat.nq;
        n_val = i_item.sat.dvs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ld) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_data <= {1'b0, n_val, n_sat, n_hue};
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/rgb8_to_hsv_converter_unit.sv =====
// Throughput: one pixel per clock unless the output stalls; the 16-bit quotients
// come from an 8-stage divider pipeline retiring two quotient bits per stage on both lanes.
// Stalls propagate stage by stage, so empty stages keep filling while output waits.
// Reset (synchronous, active low) clears only the stage valid bits.
// ------------------------------------------------------------------------
// RGB8 to HSV converter top level
// Front end, divider pipeline and back end joined by a valid/load chain.
// ------------------------------------------------------------------------
module rgb8_to_hsv_converter_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [rgbhsv_pkg::IN_W-1:0]  i_s_tdata,   // red_in, green_in, blue_in
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [rgbhsv_pkg::OUT_W-1:0] o_m_tdata    // hue_out, saturation_out, value_out, pad
);
    import rgbhsv_pkg::*;

    localparam int NSTG = DIV_STAGES + 3;

    logic [NSTG-1:0] vld;
    logic [NSTG-1:0] ld;
    t_div_item       item [DIV_STAGES+1];

    // a stage loads when it is empty or its successor loads
    always_comb begin
        ld[NSTG-1] = !vld[NSTG-1] || i_m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            ld[k] = !vld[k] || ld[k+1];
        end
    end

    assign o_s_tready = ld[0];

    rgbhsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_data  (i_s_tdata),
        .i_ld    (ld[1:0]),
        .o_valid (vld[1:0]),
        .o_item  (item[0])
    );

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        rgbhsv_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld[s+1]),
            .i_ld    (ld[s+2]),
            .i_item  (item[s]),
            .o_valid (vld[s+2]),
            .o_item  (item[s+1])
        );
    end

    rgbhsv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (vld[NSTG-2]),
        .i_ld    (ld[NSTG-1]),
        .i_item  (item[DIV_STAGES]),
        .o_valid (vld[NSTG-1]),
        .o_data  (o_m_tdata)
    );

    assign o_m_tvalid = vld[NSTG-1];

endmodule

// ===== rtl/rgbhsv_checker.sv =====
// ------------------------------------------------------------------------
// RGB8 to HSV converter checker
// Port-level properties, bound to the top level.
// ------------------------------------------------------------------------
`include "rgb8_to_hsv_converter_unit_defines.svh"

module rgbhsv_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_s_tready,
    input logic                         i_m_tvalid,
    input logic                         i_m_tready,
    input logic [rgbhsv_pkg::OUT_W-1:0] i_m_tdata
);
    import rgbhsv_pkg::*;

    logic [14:0] m_hue;
    logic [15:0] m_sat;
    logic [7:0]  m_val;
    logic        m_stall;
    logic        m_black;
    logic        m_in_range;

    assign m_hue      = i_m_tdata[14:0];
    assign m_sat      = i_m_tdata[30:15];
    assign m_val      = i_m_tdata[38:31];
    assign m_stall    = i_m_tvalid && !i_m_tready;
    assign m_black    = i_m_tvalid && (m_val == 8'd0);
    assign m_in_range = (m_hue < HUE_FULL[14:0]) && (m_sat <= 16'd32768)
                      && !i_m_tdata[OUT_W-1];

    `RGBHSV_ASSERT_RST(a_rst_clears_out, !i_rst_n |=> !i_m_tvalid, "output valid after reset")
    `RGBHSV_ASSERT(a_out_hold, m_stall |=> i_m_tvalid && $stable(i_m_tdata), "stalled output moved")
    `RGBHSV_ASSERT(a_ready_when_empty, !i_m_tvalid |-> i_s_tready, "input blocked, output empty")
    `RGBHSV_ASSERT(a_black_no_sat, m_black |-> m_sat == 16'd0, "saturation on black pixel")
    `RGBHSV_ASSERT(a_ranges, i_m_tvalid |-> m_in_range, "result out of range")

endmodule

bind rgb8_to_hsv_converter_unit rgbhsv_checker u_rgbhsv_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);
